>>> rtl/xcfr_pkg.sv
// Shared types and constants of the XOR-checked frame receiver.
`default_nettype none

package xcfr_pkg;

	localparam logic [7:0] SYNC_FIRST = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'hBB;
	localparam int REPORTED_PAYLOAD = 5;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_SERIAL,
		PH_TYPE,
		PH_DATA,
		PH_CHECK
	} phase_t;

	typedef enum logic [1:0] {
		ST_ACCEPT = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_CHECK_ERR = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [47:0] source_address;
		logic end_of_packet;
	} item_t;

	typedef struct packed {
		logic [1:0] frame_status;
		logic [7:0] serial_number;
		logic [7:0] frame_type;
		logic [7:0] payload_0;
		logic [7:0] payload_1;
		logic [7:0] payload_2;
		logic [7:0] payload_3;
		logic [7:0] payload_4;
		logic [47:0] sender_address;
	} result_t;

	// A completed frame as the parser hands it to the serial checker.
	typedef struct packed {
		logic check_ok;
		logic [7:0] serial;
		logic [7:0] ftype;
		logic [REPORTED_PAYLOAD-1:0][7:0] payload;
		logic [47:0] address;
	} frame_t;

endpackage

`default_nettype wire

>>> rtl/xor_checked_frame_receiver_unit.sv
// Usage: byte-stream receiver for frames of sync pair, serial, type, payload and XOR check.
// The input side is a queue write port: an item (byte, sender address, end-of-packet
// flag) is taken on a clock edge with push high and full low. One byte is taken every
// cycle; full only rises while the parser waits on a check byte and the frame queue
// ahead of the serial checker is full.
// The result side is a queue read port: while empty is low the oldest result sits on
// result, and pop with empty low removes it. Each check byte gives one result.
// A check byte's result passes through the frame queue and then the result buffer before
// it shows on the port; results drain at one per cycle while pop is high. The parser,
// the two-entry frame queue and the two-entry result buffer let each side stall on its own;
// a receiver that stops popping backs up the result buffer, then the frame queue, and only
// then raises full at the next check byte.
// Reset clears the parse state, both queues and the last accepted serial, so the first
// good frame after reset is always accepted. end_of_packet does not affect parsing.
`default_nettype none

module xor_checked_frame_receiver_unit #(
	parameter int PAYLOAD_BYTES = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire xcfr_pkg::item_t item,
	input wire logic pop,
	output logic empty,
	output xcfr_pkg::result_t result
);
	import xcfr_pkg::*;

	logic take;
	logic at_check;
	logic frame_push;
	frame_t frame_in;
	frame_t frame_out;
	logic q_full;
	logic q_empty;
	logic frame_pop;

	assign full = at_check && q_full;
	assign take = push && !full;

	xcfr_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.take(take),
		.at_check(at_check),
		.frame_push(frame_push),
		.frame(frame_in)
	);

	xcfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(frame_push),
		.wr_data(frame_in),
		.rd_en(frame_pop),
		.rd_data(frame_out),
		.q_full(q_full),
		.q_empty(q_empty)
	);

	xcfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_out),
		.frame_valid(!q_empty),
		.frame_pop(frame_pop),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

endmodule

`default_nettype wire

>>> rtl/xcfr_front.sv
// Byte parser: sync hunt, field capture and running XOR check.
`default_nettype none

module xcfr_front #(
	parameter int PAYLOAD_BYTES = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire xcfr_pkg::item_t item,
	input wire logic take,
	output logic at_check,
	output logic frame_push,
	output xcfr_pkg::frame_t frame
);
	import xcfr_pkg::*;

	localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

	phase_t phase_q;
	phase_t phase_d;
	logic [7:0] run_q;
	logic [7:0] serial_q;
	logic [7:0] ftype_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_inc;
	logic [REPORTED_PAYLOAD-1:0][7:0] payload;
	logic is_aa;
	logic is_bb;
	logic check_ok;
	logic last_data;

	assign is_aa = (item.rx_byte == SYNC_FIRST);
	assign is_bb = (item.rx_byte == SYNC_SECOND);
	assign check_ok = (run_q == item.rx_byte);
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign last_data = (cnt_inc >= CNT_W'(PAYLOAD_BYTES));

	always_comb begin
		phase_d = phase_q;
		if (take) begin
			unique case (phase_q)
				PH_HUNT1: phase_d = is_aa ? PH_HUNT2 : PH_HUNT1;
				PH_HUNT2: begin
					if (is_bb) begin
						phase_d = PH_SERIAL;
					end else begin
						phase_d = is_aa ? PH_HUNT2 : PH_HUNT1;
					end
				end
				PH_SERIAL: phase_d = PH_TYPE;
				PH_TYPE: phase_d = PH_DATA;
				PH_DATA: phase_d = last_data ? PH_CHECK : PH_DATA;
				PH_CHECK: begin
					// A bad check byte may itself open the next frame.
					if (!check_ok && is_aa) begin
						phase_d = PH_HUNT2;
					end else begin
						phase_d = PH_HUNT1;
					end
				end
				default: phase_d = PH_HUNT1;
			endcase
		end
	end

	always_comb begin
		at_check = (phase_q == PH_CHECK);
		frame_push = take && (phase_q == PH_CHECK);
		frame.check_ok = check_ok;
		frame.serial = serial_q;
		frame.ftype = ftype_q;
		frame.payload = payload;
		frame.address = item.source_address;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			run_q <= '0;
			serial_q <= '0;
			ftype_q <= '0;
			cnt_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (take) begin
				unique case (phase_q)
					PH_HUNT2: begin
						if (is_bb) begin
							run_q <= run_q ^ item.rx_byte;
						end else if (is_aa) begin
							run_q <= item.rx_byte;
						end
					end
					PH_SERIAL: begin
						run_q <= run_q ^ item.rx_byte;
						serial_q <= item.rx_byte;
					end
					PH_TYPE: begin
						run_q <= run_q ^ item.rx_byte;
						ftype_q <= item.rx_byte;
						cnt_q <= '0;
					end
					PH_DATA: begin
						run_q <= run_q ^ item.rx_byte;
						cnt_q <= cnt_inc;
					end
					PH_CHECK: begin
						if (!check_ok && is_aa) begin
							run_q <= item.rx_byte;
						end
					end
					default: begin
						if (is_aa) begin
							run_q <= item.rx_byte;
						end
					end
				endcase
			end
		end
	end

	// Only the reported payload bytes are kept; the rest enter the check alone.
	for (genvar k = 0; k < REPORTED_PAYLOAD; k++) begin : g_pay
		if (k < PAYLOAD_BYTES) begin : g_store
			logic [7:0] byte_q;
			always_ff @(posedge clk) begin
				if (take && (phase_q == PH_DATA) && (cnt_q == CNT_W'(k))) begin
					byte_q <= item.rx_byte;
				end
			end
			assign payload[k] = byte_q;
		end else begin : g_zero
			assign payload[k] = '0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/xcfr_queue.sv
// Short queue of completed frames between the parser and the serial checker.
`default_nettype none

module xcfr_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire xcfr_pkg::frame_t wr_data,
	input wire logic rd_en,
	output xcfr_pkg::frame_t rd_data,
	output logic q_full,
	output logic q_empty
);
	import xcfr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign q_full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/xcfr_back.sv
// Serial checker: duplicate filtering, status coding and the result buffer.
`default_nettype none

module xcfr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire xcfr_pkg::frame_t frame,
	input wire logic frame_valid,
	output logic frame_pop,
	input wire logic pop,
	output logic empty,
	output xcfr_pkg::result_t result
);
	import xcfr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [7:0] prev_serial_q;
	logic prev_valid_q;
	result_t buf_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic buf_full;
	logic do_rd;
	status_t status;
	result_t res_d;

	assign buf_full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign frame_pop = frame_valid && !buf_full;
	assign do_rd = pop && !empty;
	assign result = buf_q[rd_ptr_q];

	always_comb begin
		priority if (!frame.check_ok) begin
			status = ST_CHECK_ERR;
		end else if (!prev_valid_q || (frame.serial != prev_serial_q)) begin
			status = ST_ACCEPT;
		end else begin
			status = ST_DUPLICATE;
		end
		res_d.frame_status = status;
		res_d.serial_number = frame.serial;
		res_d.frame_type = frame.ftype;
		res_d.payload_0 = frame.payload[0];
		res_d.payload_1 = frame.payload[1];
		res_d.payload_2 = frame.payload[2];
		res_d.payload_3 = frame.payload[3];
		res_d.payload_4 = frame.payload[4];
		res_d.sender_address = frame.address;
	end

	always_ff @(posedge clk) begin
		if (frame_pop) begin
			buf_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_serial_q <= '0;
			prev_valid_q <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (frame_pop && (status == ST_ACCEPT)) begin
				prev_serial_q <= frame.serial;
				prev_valid_q <= 1'b1;
			end
			if (frame_pop) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (frame_pop && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !frame_pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire
